// ===== rtl/uole_pkg.sv =====
// ============================================================================
// uole_pkg
// Shared types, field widths and codes for the unique ordered list engine.
// ============================================================================
`default_nettype none

package uole_pkg;

    // Field widths of one transaction on each stream
    localparam int KIND_W    = 4;
    localparam int POS_W     = 6;
    localparam int REF_W     = 16;
    localparam int IDX_W     = 5;
    localparam int STAT_W    = 3;
    localparam int COUNT_W   = 6;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF   = 32;
    localparam int ID_BITS_DEF = 16;

    // Operation kinds; codes 10 to 15 are no-ops
    localparam logic [KIND_W-1:0] KIND_PUSH     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_POP_AT   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_LAST = 4'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_ERASE_AT = 4'd4;
    localparam logic [KIND_W-1:0] KIND_ERASE_ID = 4'd5;
    localparam logic [KIND_W-1:0] KIND_GET      = 4'd6;
    localparam logic [KIND_W-1:0] KIND_FIND     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CONTAINS = 4'd8;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 4'd9;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_INDEX = 3'd1,
        STAT_NIL       = 3'd2,
        STAT_DUP       = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_FULL      = 3'd5
    } t_status;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCAN,
        DP_DOWN,
        DP_UP,
        DP_STEP,
        DP_RD_POS,
        DP_RD_LAST,
        DP_WR_ID,
        DP_DONE
    } t_dp_op;

    // Length update at the end of an operation
    typedef enum logic [1:0] {
        LEN_KEEP,
        LEN_INC,
        LEN_DEC,
        LEN_CLR
    } t_len_op;

    // Walk mode of the memory sweep
    typedef enum logic [1:0] {
        MODE_SCAN,
        MODE_DOWN,
        MODE_UP
    } t_mode;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_POST,
        S_DOWN,
        S_MOVE,
        S_FIN
    } t_state;

    // Result fields handed over with DP_DONE
    typedef struct packed {
        t_status status;
        logic    changed;
        logic    use_ref;
        logic    found;
        logic    use_idx;
        t_len_op len_op;
    } t_fin;

    // Controller to datapath
    typedef struct packed {
        t_dp_op op;
        t_fin   fin;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              walk_end;
        logic              found;
        logic              id_nil;
        logic              pos_ge_len;
        logic              pos_gt_len;
        logic              empty;
        logic              full;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/uole_datapath.sv =====
// ============================================================================
// uole_datapath
// Entry memory, length register, sweep counters and result register.
// ============================================================================
`default_nettype none

module uole_datapath import uole_pkg::*; #(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [POS_W-1:0]     i_position,
    input  wire logic [REF_W-1:0]     i_ref_id,
    output t_dp_stat                  o_stat,
    // ref_out, index_out, found, status, changed, count (lowest bit up)
    output logic [M_TDATA_W-1:0]      o_result
);

    localparam int EW = (ID_BITS < REF_W) ? ID_BITS : REF_W;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int PW = (LW > POS_W) ? LW : POS_W;

    // Entry storage
    logic [EW-1:0] mem [DEPTH];

    // Item and list state
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [PW-1:0]     r_pos, n_pos;
    logic [EW-1:0]     r_id, n_id;
    logic [LW-1:0]     r_len, n_len;

    // Sweep state
    t_mode             r_mode, n_mode;
    logic [LW-1:0]     r_ptr, n_ptr;
    logic [LW-1:0]     r_rem, n_rem;
    logic              r_pv, n_pv;
    logic [AW-1:0]     r_radr, n_radr;
    logic              r_found, n_found;
    logic [EW-1:0]     r_rdata;
    logic [EW-1:0]     r_ref;

    // Result register
    logic [REF_W-1:0]   r_o_ref, n_o_ref;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;
    logic               r_o_found, n_o_found;
    logic [STAT_W-1:0]  r_o_status, n_o_status;
    logic               r_o_changed, n_o_changed;
    logic [COUNT_W-1:0] r_o_count, n_o_count;

    // Memory port controls
    logic          w_re_walk, w_re_ref, w_we;
    logic [AW-1:0] w_ra, w_wa;
    logic [EW-1:0] w_wd;
    logic          w_hit;
    logic [AW-1:0] w_move_wa;

    // Match of the entry read in the previous scan step
    assign w_hit = r_pv && (r_mode == MODE_SCAN) && (r_rdata == r_id);
    // Moved entry lands one slot above or below where it was read
    assign w_move_wa = (r_mode == MODE_UP) ? (r_radr + AW'(1)) : (r_radr - AW'(1));

    // Status toward the controller
    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.hit        = w_hit;
        o_stat.walk_end   = (r_rem == '0) && !r_pv;
        o_stat.found      = r_found;
        o_stat.id_nil     = (r_id == '0);
        o_stat.pos_ge_len = (r_pos >= PW'(r_len));
        o_stat.pos_gt_len = (r_pos > PW'(r_len));
        o_stat.empty      = (r_len == '0);
        o_stat.full       = (r_len == LW'(DEPTH));
    end

    // Next-state decode of the datapath command
    always_comb begin
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_id        = r_id;
        n_len       = r_len;
        n_mode      = r_mode;
        n_ptr       = r_ptr;
        n_rem       = r_rem;
        n_pv        = 1'b0;
        n_radr      = r_radr;
        n_found     = r_found;
        n_o_ref     = r_o_ref;
        n_o_idx     = r_o_idx;
        n_o_found   = r_o_found;
        n_o_status  = r_o_status;
        n_o_changed = r_o_changed;
        n_o_count   = r_o_count;
        w_re_walk   = 1'b0;
        w_re_ref    = 1'b0;
        w_ra        = '0;
        w_we        = 1'b0;
        w_wa        = '0;
        w_wd        = '0;

        // A scan hit records where the id sits
        if (w_hit) begin
            n_found = 1'b1;
            n_pos   = PW'(r_radr);
        end

        unique case (i_cmd.op)
            DP_LOAD: begin
                n_kind = i_kind;
                n_id   = i_ref_id[EW-1:0];
                n_pos  = (i_kind == KIND_PUSH) ? PW'(r_len) : PW'(i_position);
            end
            DP_SCAN: begin
                n_mode  = MODE_SCAN;
                n_ptr   = '0;
                n_rem   = r_len;
                n_found = 1'b0;
            end
            DP_DOWN: begin
                n_mode = MODE_DOWN;
                n_ptr  = LW'(r_pos) + LW'(1);
                n_rem  = r_len - LW'(r_pos) - LW'(1);
            end
            DP_UP: begin
                n_mode = MODE_UP;
                n_ptr  = r_len - LW'(1);
                n_rem  = r_len - LW'(r_pos);
            end
            DP_STEP: begin
                if (r_rem != '0) begin
                    w_re_walk = 1'b1;
                    w_ra      = r_ptr[AW-1:0];
                    n_radr    = r_ptr[AW-1:0];
                    n_ptr     = (r_mode == MODE_UP) ? (r_ptr - LW'(1)) : (r_ptr + LW'(1));
                    n_rem     = r_rem - LW'(1);
                    n_pv      = 1'b1;
                end
                if (r_pv && (r_mode != MODE_SCAN)) begin
                    w_we = 1'b1;
                    w_wa = w_move_wa;
                    w_wd = r_rdata;
                end
            end
            DP_RD_POS: begin
                w_re_ref = 1'b1;
                w_ra     = r_pos[AW-1:0];
            end
            DP_RD_LAST: begin
                w_re_ref = 1'b1;
                w_ra     = AW'(r_len - LW'(1));
            end
            DP_WR_ID: begin
                w_we = 1'b1;
                w_wa = r_pos[AW-1:0];
                w_wd = r_id;
            end
            DP_DONE: begin
                case (i_cmd.fin.len_op)
                    LEN_INC: n_len = r_len + LW'(1);
                    LEN_DEC: n_len = r_len - LW'(1);
                    LEN_CLR: n_len = '0;
                    default: n_len = r_len;
                endcase
                n_o_ref     = i_cmd.fin.use_ref ? REF_W'(r_ref) : '0;
                n_o_idx     = i_cmd.fin.use_idx ? IDX_W'(r_pos) : '0;
                n_o_found   = i_cmd.fin.found;
                n_o_status  = i_cmd.fin.status;
                n_o_changed = i_cmd.fin.changed;
                n_o_count   = COUNT_W'(n_len);
            end
            default: begin
            end
        endcase
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re_walk) begin
            r_rdata <= mem[w_ra];
        end
        if (w_re_ref) begin
            r_ref <= mem[w_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_pv  <= 1'b0;
            r_rem <= '0;
        end else begin
            r_len <= n_len;
            r_pv  <= n_pv;
            r_rem <= n_rem;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_pos       <= n_pos;
        r_id        <= n_id;
        r_mode      <= n_mode;
        r_ptr       <= n_ptr;
        r_radr      <= n_radr;
        r_found     <= n_found;
        r_o_ref     <= n_o_ref;
        r_o_idx     <= n_o_idx;
        r_o_found   <= n_o_found;
        r_o_status  <= n_o_status;
        r_o_changed <= n_o_changed;
        r_o_count   <= n_o_count;
    end

    assign o_result = {r_o_count, r_o_changed, r_o_status, r_o_found, r_o_idx, r_o_ref};

endmodule

`default_nettype wire

// ===== rtl/uole_ctrl.sv =====
// ============================================================================
// uole_ctrl
// Sequencer: checks, scan, shift, result hand-off and stream handshakes.
// ============================================================================
`default_nettype none

module uole_ctrl import uole_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_valid,
    output logic          o_s_ready,
    output logic          o_m_valid,
    input  wire logic     i_m_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_ovld, n_ovld;
    t_fin    w_fin;
    logic    w_ok;

    assign w_ok = (r_status == STAT_OK);

    // Result fields from kind and outcome
    always_comb begin
        w_fin.status  = r_status;
        w_fin.changed = 1'b0;
        w_fin.use_ref = 1'b0;
        w_fin.found   = 1'b0;
        w_fin.use_idx = 1'b0;
        w_fin.len_op  = LEN_KEEP;
        case (i_stat.kind) inside
            KIND_PUSH, KIND_INSERT: begin
                w_fin.changed = w_ok;
                w_fin.len_op  = w_ok ? LEN_INC : LEN_KEEP;
            end
            KIND_POP_AT, KIND_POP_LAST: begin
                w_fin.changed = w_ok;
                w_fin.use_ref = w_ok;
                w_fin.len_op  = w_ok ? LEN_DEC : LEN_KEEP;
            end
            KIND_ERASE_AT, KIND_ERASE_ID: begin
                w_fin.changed = w_ok;
                w_fin.len_op  = w_ok ? LEN_DEC : LEN_KEEP;
            end
            KIND_GET: begin
                w_fin.use_ref = w_ok;
            end
            KIND_FIND: begin
                w_fin.found   = i_stat.found;
                w_fin.use_idx = i_stat.found;
            end
            KIND_CONTAINS: begin
                w_fin.found = i_stat.found;
            end
            KIND_CLEAR: begin
                w_fin.changed = !i_stat.empty;
                w_fin.len_op  = LEN_CLR;
            end
            default: begin
            end
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_ovld     = r_ovld;
        o_cmd.op   = DP_NOP;
        o_cmd.fin  = w_fin;
        o_s_ready  = 1'b0;

        // Result leaves on its transaction
        if (r_ovld && i_m_ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status = STAT_OK;
                n_state  = S_FIN;
                case (i_stat.kind) inside
                    KIND_PUSH: begin
                        if (i_stat.id_nil) begin
                            n_status = STAT_NIL;
                        end else begin
                            o_cmd.op = DP_SCAN;
                            n_state  = S_SCAN;
                        end
                    end
                    KIND_INSERT: begin
                        if (i_stat.pos_gt_len) begin
                            n_status = STAT_BAD_INDEX;
                        end else begin
                            o_cmd.op = DP_SCAN;
                            n_state  = S_SCAN;
                        end
                    end
                    KIND_POP_AT: begin
                        if (i_stat.pos_ge_len) begin
                            n_status = STAT_BAD_INDEX;
                        end else begin
                            o_cmd.op = DP_RD_POS;
                            n_state  = S_DOWN;
                        end
                    end
                    KIND_ERASE_AT: begin
                        if (i_stat.pos_ge_len) begin
                            n_status = STAT_BAD_INDEX;
                        end else begin
                            o_cmd.op = DP_DOWN;
                            n_state  = S_MOVE;
                        end
                    end
                    KIND_POP_LAST: begin
                        if (i_stat.empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            o_cmd.op = DP_RD_LAST;
                        end
                    end
                    KIND_GET: begin
                        if (i_stat.pos_ge_len) begin
                            n_status = STAT_BAD_INDEX;
                        end else begin
                            o_cmd.op = DP_RD_POS;
                        end
                    end
                    KIND_ERASE_ID, KIND_FIND, KIND_CONTAINS: begin
                        o_cmd.op = DP_SCAN;
                        n_state  = S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.walk_end) begin
                    n_state = S_POST;
                end else begin
                    o_cmd.op = DP_STEP;
                end
            end
            S_POST: begin
                n_state = S_FIN;
                case (i_stat.kind) inside
                    KIND_PUSH, KIND_INSERT: begin
                        if (i_stat.found) begin
                            n_status = STAT_DUP;
                        end else if (i_stat.id_nil) begin
                            n_status = STAT_NIL;
                        end else if (i_stat.full) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_cmd.op = DP_UP;
                            n_state  = S_MOVE;
                        end
                    end
                    KIND_ERASE_ID: begin
                        if (!i_stat.found) begin
                            n_status = STAT_BAD_INDEX;
                        end else begin
                            o_cmd.op = DP_DOWN;
                            n_state  = S_MOVE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DOWN: begin
                o_cmd.op = DP_DOWN;
                n_state  = S_MOVE;
            end
            S_MOVE: begin
                if (i_stat.walk_end) begin
                    if ((i_stat.kind == KIND_PUSH) || (i_stat.kind == KIND_INSERT)) begin
                        o_cmd.op = DP_WR_ID;
                    end
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = DP_STEP;
                end
            end
            S_FIN: begin
                // Wait for the result register to be free
                if (!r_ovld || i_m_ready) begin
                    o_cmd.op = DP_DONE;
                    n_ovld   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= STAT_OK;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_ovld   <= n_ovld;
        end
    end

    assign o_m_valid = r_ovld;

endmodule

`default_nettype wire

// ===== rtl/unique_ordered_list_engine.sv =====
// ============================================================================
// unique_ordered_list_engine
// Ordered list of unique non-nil ids with positional insert and removal.
// ============================================================================
// Usage:
//   Operations enter on the slave stream (kind, position, ref_id) and each
//   produces exactly one result transaction on the master stream (ref_out,
//   index_out, found, status, changed, count).
//   One operation is in flight at a time. Get, pop from end, clear, no-ops
//   and operations that fail their first check go from the checks straight
//   to the result. An id scan reads the whole list on a miss and stops at
//   the match on a hit; a shift moves the entries after the affected slot
//   by one, and pop_at first reads its entry. The longest operation is an
//   insert at the head of a list of DEPTH-1 entries. The single memory read
//   port takes one entry per cycle. The next input transaction is taken in
//   the cycle after the result is written.
//   A new operation is taken while the previous result still waits; a
//   stalled receiver holds the result and the block waits before writing
//   the next one.
//   Reset empties the list at once; entry memory is not cleared.
// ============================================================================
`default_nettype none

module unique_ordered_list_engine import uole_pkg::*; #(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // kind[3:0], position[9:4], ref_id[25:10], zero fill above
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // ref_out[15:0], index_out[20:16], found[21], status[24:22],
    // changed[25], count[31:26]
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int KIND_LSB = 0;
    localparam int POS_LSB  = KIND_LSB + KIND_W;
    localparam int REF_LSB  = POS_LSB + POS_W;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    uole_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    uole_datapath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_kind     (i_s_axis_tdata[KIND_LSB +: KIND_W]),
        .i_position (i_s_axis_tdata[POS_LSB +: POS_W]),
        .i_ref_id   (i_s_axis_tdata[REF_LSB +: REF_W]),
        .o_stat     (w_stat),
        .o_result   (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
